// File: rtl/s2cd_pkg.sv
// Package for the seconds-to-calendar-date converter.
// Holds the sequencer state type, the time constants and the month length table.
// No dependencies.
package s2cd_pkg;

  // Time constants
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;

  // Field and working widths
  localparam int unsigned EpochW = 32;
  localparam int unsigned LocalW = EpochW + 1;   // epoch plus zone offset
  localparam int unsigned DaysW  = 17;           // local / 86400 fits here
  localparam int unsigned SodW   = 17;           // seconds of the day
  localparam int unsigned ZoneW  = 4;
  localparam int unsigned CntW   = 5;

  // Quotient bit counts of the three long divisions
  localparam int unsigned DayQBits  = DaysW;
  localparam int unsigned HourQBits = 5;
  localparam int unsigned MinQBits  = 6;

  // Year bookkeeping: the year is kept as an offset from 1970
  localparam int unsigned YoffW        = 8;
  localparam int unsigned YearsTo2000  = 30;
  localparam int unsigned YearsTo2100  = 130;   // century year that is not leap
  localparam int unsigned LastYoff     = 136;   // 2106
  localparam int unsigned DaysPerYear  = 365;
  localparam int unsigned DaysLeapYear = 366;

  // Month bookkeeping
  localparam logic [3:0] MonJan = 4'd0;
  localparam logic [3:0] MonFeb = 4'd1;
  localparam logic [3:0] MonDec = 4'd11;
  localparam logic [4:0] DaysFebLeap = 5'd29;
  localparam logic [ZoneW-1:0] ZoneReset = 4'd8;

  // Month lengths of a common year, January first
  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } s2cd_state_t;

endpackage

// File: rtl/seconds_to_calendar_date.sv
// Top level of the seconds-to-calendar-date converter.
// Depends on s2cd_pkg for constants, the month table and the state type.
//
// Converts a 32-bit count of seconds since 1970-01-01 UTC into a local date
// and time: the zone offset register (hours, reset 8) is added first, then a
// single 34-bit compare-and-subtract unit does all the work under a small
// sequencer. It runs a 17-step long division by 86400, 5 steps by 3600 and
// 6 steps by 60, then strips one year per cycle from 1970 and one month per
// cycle from January. The whole years after 1970 run 0..136 and the month
// index 0..11. The input is ready only while the sequencer is idle; the
// result sits in an output register while the next item is accepted and
// processed, and a finished item waits for that register.
module seconds_to_calendar_date
  import s2cd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration
  input  logic                    cfg_wr_en,
  input  logic [ZoneW-1:0]        cfg_wr_data,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [EpochW-1:0]       in_epoch_seconds,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [7:0]       out_year_from_2000,
  output logic [3:0]              out_month_number,
  output logic [4:0]              out_day_of_month,
  output logic [4:0]              out_hour_of_day,
  output logic [5:0]              out_minute_of_hour,
  output logic [5:0]              out_second_of_minute
);

  s2cd_state_t state_r, state_nxt;

  logic [ZoneW-1:0]  zone_r;
  logic [LocalW-1:0] rem_r, rem_nxt;
  logic [DaysW-1:0]  quot_r, quot_nxt;
  logic [DaysW-1:0]  days_r, days_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        min_r, min_nxt;
  logic [5:0]        sec_r, sec_nxt;
  logic [YoffW-1:0]  yoff_r, yoff_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        o_year_r, o_year_nxt;
  logic [3:0]        o_mon_r, o_mon_nxt;
  logic [4:0]        o_day_r, o_day_nxt;
  logic [4:0]        o_hour_r, o_hour_nxt;
  logic [5:0]        o_min_r, o_min_nxt;
  logic [5:0]        o_sec_r, o_sec_nxt;

  logic [LocalW-1:0] sub_b;
  logic [LocalW:0]   sub_diff;
  logic              sub_ge;
  logic [LocalW-1:0] rem_step;
  logic              leap;
  logic [4:0]        mon_len;
  logic              in_fire;
  logic              out_load;
  logic              cnt_last;
  logic [LocalW-1:0] local_secs;

  // Handshake status
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  assign cnt_last = (cnt_r == '0);

  // Leap rule for 1970..2106: every fourth year from 1972, except 2100
  assign leap = (yoff_r[1:0] == 2'd2) && (yoff_r != YoffW'(YearsTo2100));

  // Length of the current month
  always_comb begin
    mon_len = MONTH_DAYS[mon_r];
    if (mon_r == MonFeb && leap) begin
      mon_len = DaysFebLeap;
    end
  end

  // Local second count at acceptance
  assign local_secs = LocalW'(in_epoch_seconds)
                    + LocalW'(zone_r) * LocalW'(SecsPerHour);

  // Shared compare-and-subtract unit
  assign sub_diff = {1'b0, rem_r} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[LocalW];
  assign rem_step = sub_ge ? sub_diff[LocalW-1:0] : rem_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DIV_DAY;
        end
      end
      ST_DIV_DAY: begin
        if (cnt_last) begin
          state_nxt = ST_DIV_HOUR;
        end
      end
      ST_DIV_HOUR: begin
        if (cnt_last) begin
          state_nxt = ST_DIV_MIN;
        end
      end
      ST_DIV_MIN: begin
        if (cnt_last) begin
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (!sub_ge) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (mon_r == MonDec || !sub_ge) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input ready and the operand of the shared unit
  always_comb begin
    in_ready = 1'b0;
    sub_b    = '0;
    case (state_r)
      ST_IDLE:     in_ready = 1'b1;
      ST_DIV_DAY:  sub_b = LocalW'(SecsPerDay) << cnt_r;
      ST_DIV_HOUR: sub_b = LocalW'(SecsPerHour) << cnt_r;
      ST_DIV_MIN:  sub_b = LocalW'(SecsPerMin) << cnt_r;
      ST_YEAR:     sub_b = leap ? LocalW'(DaysLeapYear) : LocalW'(DaysPerYear);
      ST_MONTH:    sub_b = LocalW'(mon_len);
      ST_FINISH:   sub_b = '0;
      default:     sub_b = '0;
    endcase
  end

  // Datapath next values
  always_comb begin
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    days_nxt      = days_r;
    cnt_nxt       = cnt_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    yoff_nxt      = yoff_r;
    mon_nxt       = mon_r;
    out_valid_nxt = out_valid_r;
    o_year_nxt    = o_year_r;
    o_mon_nxt     = o_mon_r;
    o_day_nxt     = o_day_r;
    o_hour_nxt    = o_hour_r;
    o_min_nxt     = o_min_r;
    o_sec_nxt     = o_sec_r;

    // A taken result frees the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rem_nxt  = local_secs;
          quot_nxt = '0;
          cnt_nxt  = CntW'(DayQBits - 1);
        end
      end
      ST_DIV_DAY: begin
        rem_nxt  = rem_step;
        quot_nxt = {quot_r[DaysW-2:0], sub_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_last) begin
          days_nxt = {quot_r[DaysW-2:0], sub_ge};
          quot_nxt = '0;
          cnt_nxt  = CntW'(HourQBits - 1);
        end
      end
      ST_DIV_HOUR: begin
        rem_nxt  = rem_step;
        quot_nxt = {quot_r[DaysW-2:0], sub_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_last) begin
          hour_nxt = {quot_r[3:0], sub_ge};
          quot_nxt = '0;
          cnt_nxt  = CntW'(MinQBits - 1);
        end
      end
      ST_DIV_MIN: begin
        rem_nxt  = rem_step;
        quot_nxt = {quot_r[DaysW-2:0], sub_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_last) begin
          min_nxt  = {quot_r[4:0], sub_ge};
          sec_nxt  = rem_step[5:0];
          rem_nxt  = LocalW'(days_r);
          yoff_nxt = '0;
        end
      end
      ST_YEAR: begin
        if (sub_ge) begin
          rem_nxt  = rem_step;
          yoff_nxt = yoff_r + 1'b1;
        end else begin
          mon_nxt = MonJan;
        end
      end
      ST_MONTH: begin
        if (mon_r != MonDec && sub_ge) begin
          rem_nxt = rem_step;
          mon_nxt = mon_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          o_year_nxt    = yoff_r - 8'(YearsTo2000);
          o_mon_nxt     = mon_r + 1'b1;
          o_day_nxt     = rem_r[4:0] + 1'b1;
          o_hour_nxt    = hour_r;
          o_min_nxt     = min_r;
          o_sec_nxt     = sec_r;
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      zone_r      <= ZoneReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        zone_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    quot_r   <= quot_nxt;
    days_r   <= days_nxt;
    cnt_r    <= cnt_nxt;
    hour_r   <= hour_nxt;
    min_r    <= min_nxt;
    sec_r    <= sec_nxt;
    yoff_r   <= yoff_nxt;
    mon_r    <= mon_nxt;
    o_year_r <= o_year_nxt;
    o_mon_r  <= o_mon_nxt;
    o_day_r  <= o_day_nxt;
    o_hour_r <= o_hour_nxt;
    o_min_r  <= o_min_nxt;
    o_sec_r  <= o_sec_nxt;
  end

  // Result ports
  assign out_valid            = out_valid_r;
  assign out_year_from_2000   = signed'(o_year_r);
  assign out_month_number     = o_mon_r;
  assign out_day_of_month     = o_day_r;
  assign out_hour_of_day      = o_hour_r;
  assign out_minute_of_hour   = o_min_r;
  assign out_second_of_minute = o_sec_r;

  // Checks on the sequencer and the result register
  a_fire_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_DIV_DAY)
    else $error("accepted item did not start the day division");

  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MONTH |-> yoff_r <= YoffW'(LastYoff))
    else $error("year count ran past 2106");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_mon_r >= 4'd1 && o_mon_r <= 4'd12))
    else $error("result month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_day_r >= 5'd1 && o_hour_r <= 5'd23))
    else $error("result day or hour out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(o_year_r) && $stable(o_day_r))
    else $error("result register overwritten while waiting");

endmodule
